[sv/optc_pkg.sv]
package optc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int IT_W = 5;
	localparam int MA_W = 38;
	localparam int MB_W = 18;
	localparam int ACC_W = 66;

	localparam logic signed [16:0] PI_Q13 = 17'sd25736;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032874;

	typedef enum logic {
		OP_GOAL = 1'b0,
		OP_POSE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_GAIN_X = 2'd0,
		REG_GAIN_Y = 2'd1,
		REG_GAIN_TURN = 2'd2,
		REG_STOP_RADIUS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic sub;
		logic sh16;
	} mac_ctl_t;

	function automatic logic signed [16:0] atan_q13(input logic [IT_W-1:0] i);
		logic signed [16:0] r;
		case (i)
			5'd0: r = 17'sd6434;
			5'd1: r = 17'sd3798;
			5'd2: r = 17'sd2007;
			5'd3: r = 17'sd1019;
			5'd4: r = 17'sd511;
			5'd5: r = 17'sd256;
			5'd6: r = 17'sd128;
			5'd7: r = 17'sd64;
			5'd8: r = 17'sd32;
			5'd9: r = 17'sd16;
			5'd10: r = 17'sd8;
			5'd11: r = 17'sd4;
			5'd12: r = 17'sd2;
			5'd13: r = 17'sd1;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
			r = v[31:0];
		end else if (v[ACC_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

[sv/optc_if.sv]
interface optc_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic past_end;
	modport source(output valid, opcode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
		past_end, input ready);
	modport sink(input valid, opcode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
		past_end, output ready);
endinterface

interface optc_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] turn_rate;
	logic stopped;
	modport source(output valid, vel_x, vel_y, turn_rate, stopped, input ready);
	modport sink(input valid, vel_x, vel_y, turn_rate, stopped, output ready);
endinterface

[sv/optc_mac.sv]
module optc_mac
	import optc_pkg::*;
(
	input logic clk,
	input mac_ctl_t ctl,
	input logic signed [MA_W-1:0] a,
	input logic signed [MB_W-1:0] b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [MA_W+MB_W-1:0] prod;
	logic signed [ACC_W-1:0] ext;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;

	assign prod = a * b;
	assign ext = ACC_W'(prod);
	assign term = ctl.sh16 ? (ext <<< 16) : ext;
	assign base = ctl.clr ? '0 : acc;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc <= ctl.sub ? (base - term) : (base + term);
		end
	end

endmodule

[sv/omni_pose_tracking_controller_core.sv]
// A goal item runs from transfer to goal update; a pose item from transfer to result valid,
// passing through the stop test states when that test runs. Both run on the shared CORDIC
// and the shared MAC.
// One item at a time; the next transfer can come in the cycle after the last state.
// A result still held stalls the last state.
// Reset (arst_n low, async): gains 0.5/0.5/1.0, stop radius 3277, goal cleared, idle.
module omni_pose_tracking_controller_core
	import optc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [30:0] cfg_wdata,
	optc_req_if.sink req,
	optc_rsp_if.source rsp
);

	typedef enum logic [23:0] {
		ST_IDLE  = 24'h000001,
		ST_QZW   = 24'h000002,
		ST_QXY   = 24'h000004,
		ST_QYY   = 24'h000008,
		ST_QZZ   = 24'h000010,
		ST_VINIT = 24'h000020,
		ST_VITER = 24'h000040,
		ST_VEND  = 24'h000080,
		ST_DIFF  = 24'h000100,
		ST_RNG   = 24'h000200,
		ST_SQ    = 24'h000400,
		ST_SQEND = 24'h000800,
		ST_GX    = 24'h001000,
		ST_GY    = 24'h002000,
		ST_RINIT = 24'h004000,
		ST_RITER = 24'h008000,
		ST_REND  = 24'h010000,
		ST_VX0   = 24'h020000,
		ST_VX1   = 24'h040000,
		ST_VY0   = 24'h080000,
		ST_VY1   = 24'h100000,
		ST_TR0   = 24'h200000,
		ST_TR1   = 24'h400000,
		ST_DONE  = 24'h800000
	} state_t;

	state_t st_q;

	logic [15:0] gain_x_q, gain_y_q, gain_turn_q;
	logic [30:0] stop_radius_q;
	logic signed [31:0] goal_x_q, goal_y_q;
	logic signed [15:0] goal_yaw_q;

	logic op_q, past_end_q;
	logic signed [31:0] px_q, py_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [35:0] num_q, cx_q, cy_q;
	logic signed [16:0] cz_q;
	logic [IT_W-1:0] it_q;
	logic neg_q, stop_q;
	logic signed [15:0] yaw_q;
	logic signed [32:0] dx_q, dy_q;
	logic [30:0] ax_q, ay_q;
	logic signed [MA_W-1:0] gx_q, gy_q;
	logic signed [MB_W-1:0] c_q, s_q;
	logic signed [31:0] vx_q, vy_q, tr_q;

	logic ov_q;
	logic signed [31:0] ovx_q, ovy_q, otr_q;
	logic ostop_q;

	mac_ctl_t mctl;
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic signed [ACC_W-1:0] acc;

	optc_mac u_mac (
		.clk(clk),
		.ctl(mctl),
		.a(ma),
		.b(mb),
		.acc(acc)
	);

	logic signed [35:0] xs, ys, den, xr;
	logic signed [16:0] at, zc, dyaw, th;
	logic dpos, it_last, rng_ok, out_free;

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = atan_q13(it_q);
	assign dpos = (st_q == ST_VITER) ? (cy_q <= 36'sd0) : !cz_q[16];
	assign it_last = (it_q == IT_W'(CORDIC_STEPS - 1));
	assign den = (36'sd1 <<< 28) - 36'(acc <<< 1);
	assign zc = (cz_q > PI_Q13) ? PI_Q13 : ((cz_q < -PI_Q13) ? -PI_Q13 : cz_q);
	assign dyaw = 17'(goal_yaw_q) - 17'(yaw_q);
	assign th = 17'(yaw_q);
	assign xr = neg_q ? -cx_q : cx_q;
	assign rng_ok = (dx_q[32] == dx_q[31]) && (dx_q != -33'sh80000000) &&
		(dy_q[32] == dy_q[31]) && (dy_q != -33'sh80000000);
	assign out_free = !ov_q || rsp.ready;

	assign req.ready = (st_q == ST_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.vel_x = ovx_q;
	assign rsp.vel_y = ovy_q;
	assign rsp.turn_rate = otr_q;
	assign rsp.stopped = ostop_q;

	always_comb begin
		mctl = '0;
		ma = '0;
		mb = '0;
		case (st_q)
			ST_QZW: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(qz_q);
				mb = MB_W'(qw_q);
			end
			ST_QXY: begin
				mctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(qx_q);
				mb = MB_W'(qy_q);
			end
			ST_QYY: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(qy_q);
				mb = MB_W'(qy_q);
			end
			ST_QZZ: begin
				mctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(qz_q);
				mb = MB_W'(qz_q);
			end
			ST_SQ: begin
				mctl.en = 1'b1;
				mctl.clr = (it_q == '0);
				mctl.sh16 = !it_q[0];
				mctl.sub = (it_q[2:1] == 2'd2);
				case (it_q[2:1])
					2'd0: begin
						ma = MA_W'(ax_q);
						mb = it_q[0] ? MB_W'(ax_q[15:0]) : MB_W'(ax_q[30:16]);
					end
					2'd1: begin
						ma = MA_W'(ay_q);
						mb = it_q[0] ? MB_W'(ay_q[15:0]) : MB_W'(ay_q[30:16]);
					end
					default: begin
						ma = MA_W'(stop_radius_q);
						mb = it_q[0] ? MB_W'(stop_radius_q[15:0]) :
							MB_W'(stop_radius_q[30:16]);
					end
				endcase
			end
			ST_GX: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(dx_q);
				mb = MB_W'(gain_x_q);
			end
			ST_GY: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(dy_q);
				mb = MB_W'(gain_y_q);
			end
			ST_VX0: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = gx_q;
				mb = c_q;
			end
			ST_VX1: begin
				mctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh16: 1'b0};
				ma = gy_q;
				mb = s_q;
			end
			ST_VY0: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = gy_q;
				mb = c_q;
			end
			ST_VY1: begin
				mctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh16: 1'b0};
				ma = gx_q;
				mb = s_q;
			end
			ST_TR0: begin
				mctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh16: 1'b0};
				ma = MA_W'(dyaw);
				mb = MB_W'(gain_turn_q);
			end
			default: begin
				mctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q <= 16'd2048;
			gain_y_q <= 16'd2048;
			gain_turn_q <= 16'd4096;
			stop_radius_q <= 31'd3277;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_GAIN_X: gain_x_q <= cfg_wdata[15:0];
				REG_GAIN_Y: gain_y_q <= cfg_wdata[15:0];
				REG_GAIN_TURN: gain_turn_q <= cfg_wdata[15:0];
				REG_STOP_RADIUS: stop_radius_q <= cfg_wdata;
				default: gain_x_q <= gain_x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			goal_x_q <= '0;
			goal_y_q <= '0;
			goal_yaw_q <= '0;
			ov_q <= 1'b0;
			it_q <= '0;
		end else begin
			if (rsp.ready && st_q != ST_DONE) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (req.valid) begin
						st_q <= ST_QZW;
					end
				end
				ST_QZW: st_q <= ST_QXY;
				ST_QXY: st_q <= ST_QYY;
				ST_QYY: st_q <= ST_QZZ;
				ST_QZZ: st_q <= ST_VINIT;
				ST_VINIT: begin
					it_q <= '0;
					st_q <= (num_q == '0 && den == '0) ? ST_VEND : ST_VITER;
				end
				ST_VITER: begin
					it_q <= it_q + 1'b1;
					if (it_last) begin
						st_q <= ST_VEND;
					end
				end
				ST_VEND: begin
					if (op_q == OP_GOAL) begin
						goal_x_q <= px_q;
						goal_y_q <= py_q;
						goal_yaw_q <= 16'(zc);
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_DIFF;
					end
				end
				ST_DIFF: st_q <= ST_RNG;
				ST_RNG: begin
					it_q <= '0;
					st_q <= (past_end_q && rng_ok) ? ST_SQ : ST_GX;
				end
				ST_SQ: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(5)) begin
						st_q <= ST_SQEND;
					end
				end
				ST_SQEND: begin
					st_q <= (acc[ACC_W-1] || acc == '0) ? ST_DONE : ST_GX;
				end
				ST_GX: st_q <= ST_GY;
				ST_GY: st_q <= ST_RINIT;
				ST_RINIT: begin
					it_q <= '0;
					st_q <= ST_RITER;
				end
				ST_RITER: begin
					it_q <= it_q + 1'b1;
					if (it_last) begin
						st_q <= ST_REND;
					end
				end
				ST_REND: st_q <= ST_VX0;
				ST_VX0: st_q <= ST_VX1;
				ST_VX1: st_q <= ST_VY0;
				ST_VY0: st_q <= ST_VY1;
				ST_VY1: st_q <= ST_TR0;
				ST_TR0: st_q <= ST_TR1;
				ST_TR1: st_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				op_q <= req.opcode;
				past_end_q <= req.past_end;
				px_q <= req.pos_x;
				py_q <= req.pos_y;
				qx_q <= req.quat_x;
				qy_q <= req.quat_y;
				qz_q <= req.quat_z;
				qw_q <= req.quat_w;
			end
			ST_QYY: num_q <= 36'(acc <<< 1);
			ST_VINIT: begin
				if (num_q == '0 && den == '0) begin
					cz_q <= '0;
				end else if (den < 0) begin
					cx_q <= -den;
					cy_q <= -num_q;
					cz_q <= (num_q >= 0) ? PI_Q13 : -PI_Q13;
				end else begin
					cx_q <= den;
					cy_q <= num_q;
					cz_q <= '0;
				end
			end
			ST_VITER, ST_RITER: begin
				cx_q <= dpos ? (cx_q - ys) : (cx_q + ys);
				cy_q <= dpos ? (cy_q + xs) : (cy_q - xs);
				cz_q <= dpos ? (cz_q - at) : (cz_q + at);
			end
			ST_VEND: yaw_q <= 16'(zc);
			ST_DIFF: begin
				dx_q <= 33'(goal_x_q) - 33'(px_q);
				dy_q <= 33'(goal_y_q) - 33'(py_q);
			end
			ST_RNG: begin
				stop_q <= 1'b0;
				ax_q <= 31'(dx_q[32] ? -dx_q : dx_q);
				ay_q <= 31'(dy_q[32] ? -dy_q : dy_q);
			end
			ST_SQEND: stop_q <= acc[ACC_W-1] || acc == '0;
			ST_GY: gx_q <= MA_W'((acc + 66'sd2048) >>> 12);
			ST_RINIT: begin
				gy_q <= MA_W'((acc + 66'sd2048) >>> 12);
				cx_q <= INV_GAIN_Q30;
				cy_q <= '0;
				if (th > HALF_PI_Q13) begin
					cz_q <= th - PI_Q13;
					neg_q <= 1'b1;
				end else if (th < -HALF_PI_Q13) begin
					cz_q <= th + PI_Q13;
					neg_q <= 1'b1;
				end else begin
					cz_q <= th;
					neg_q <= 1'b0;
				end
			end
			ST_REND: begin
				c_q <= MB_W'((xr + 36'sd32768) >>> 16);
				s_q <= MB_W'(((neg_q ? -cy_q : cy_q) + 36'sd32768) >>> 16);
			end
			ST_VY0: vx_q <= sat32((acc + 66'sd8192) >>> 14);
			ST_TR0: vy_q <= sat32((acc + 66'sd8192) >>> 14);
			ST_TR1: tr_q <= sat32((acc + 66'sd256) >>> 9);
			ST_DONE: begin
				if (out_free) begin
					ovx_q <= stop_q ? '0 : vx_q;
					ovy_q <= stop_q ? '0 : vy_q;
					otr_q <= stop_q ? '0 : tr_q;
					ostop_q <= stop_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.stopped |-> rsp.vel_x == 0 && rsp.vel_y == 0 && rsp.turn_rate == 0)
		else $error("stopped result with nonzero command");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(st_q == ST_DONE))
		else $error("result raised outside done state");

	a_goal_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_VEND && op_q == OP_GOAL |=> st_q == ST_IDLE)
		else $error("goal item went on past yaw");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIFF |-> 17'(yaw_q) <= PI_Q13 && 17'(yaw_q) >= -PI_Q13)
		else $error("yaw outside clamp");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accepted while busy");

endmodule
